@@ hw/rtl/kpt_pkg.sv @@
// kpt_pkg: shared widths, command and status codes, and entry layout for the
// keyed peer table. No dependencies.

package kpt_pkg;

	localparam int WORD_W            = 64;
	localparam int KEY_W             = 4 * WORD_W;
	localparam int ID_W              = 16;
	localparam int SLOT_W            = 4;
	localparam int LIVE_W            = 5;
	localparam int DEF_TABLE_ENTRIES = 16;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_FIND_KEY = 2'd1,
		CMD_FIND_ID  = 2'd2,
		CMD_REMOVE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_DONE      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One stored entry: id above the 256-bit key.
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Control into the compare unit.
	typedef struct packed {
		logic by_id;
		logic live;
	} probe_t;

endpackage

@@ hw/rtl/kpt_ram.sv @@
// kpt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module kpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/kpt_match.sv @@
// kpt_match: the shared compare unit, matching one stored entry against the
// key or the id of the current command. Depends on kpt_pkg.

module kpt_match (
	input  kpt_pkg::probe_t                probe,
	input  logic [kpt_pkg::KEY_W-1:0]      key,
	input  logic [kpt_pkg::ID_W-1:0]       id,
	input  kpt_pkg::entry_t                entry,
	output logic                           hit
);

	logic key_eq;
	logic id_eq;

	assign key_eq = (entry.key == key);
	assign id_eq  = (entry.id == id);
	// Only a live entry can match.
	assign hit    = probe.live && (probe.by_id ? id_eq : key_eq);

endmodule

@@ hw/rtl/keyed_peer_table.sv @@
// keyed_peer_table: associative table of peer keys and ids with first-free
// insert. Depends on kpt_pkg, kpt_ram and kpt_match.
//
// Each command is one transaction on the input channel and gives exactly one
// transaction on the output channel. After a command is accepted the block
// scans the entry RAM one slot per cycle through its single read port and one
// shared comparator, stopping at the lowest live match or after the last slot
// (miss, or insert into a free slot); the input channel stalls while the scan
// runs and until the result is committed. Valid marks sit in flip-flops and
// the live count in a register, both cleared by reset, so the table is usable
// right after reset with no clearing pass. A finished result waits in an
// output register, so the next command is taken while that result is still
// stalled; the new result is loaded only once the old one has left.

module keyed_peer_table #(
	parameter int TABLE_ENTRIES = kpt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [kpt_pkg::WORD_W-1:0]     key_word0,
	input  logic [kpt_pkg::WORD_W-1:0]     key_word1,
	input  logic [kpt_pkg::WORD_W-1:0]     key_word2,
	input  logic [kpt_pkg::WORD_W-1:0]     key_word3,
	input  logic [kpt_pkg::ID_W-1:0]       peer_id,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [kpt_pkg::SLOT_W-1:0]     slot,
	output logic [kpt_pkg::ID_W-1:0]       stored_id,
	output logic [kpt_pkg::WORD_W-1:0]     found_key_word0,
	output logic [kpt_pkg::WORD_W-1:0]     found_key_word1,
	output logic [kpt_pkg::WORD_W-1:0]     found_key_word2,
	output logic [kpt_pkg::WORD_W-1:0]     found_key_word3,
	output logic [kpt_pkg::LIVE_W-1:0]     live_count
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	// sequencer and table control
	state_t                      state_q;
	logic                        out_valid_q;
	logic [TABLE_ENTRIES-1:0]    valid_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rd_cnt_q;
	logic                        cmp_vld_s1;
	logic                        cmp_last_s1;
	logic [IW-1:0]               cmp_idx_s1;
	logic                        match_q;
	logic [IW-1:0]               match_idx_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;

	// command and match payload
	kpt_pkg::cmd_t               cmd_q;
	logic [kpt_pkg::KEY_W-1:0]   key_q;
	logic [kpt_pkg::ID_W-1:0]    id_q;
	kpt_pkg::entry_t             match_entry_q;

	// result payload
	kpt_pkg::status_t            status_q;
	logic [kpt_pkg::SLOT_W-1:0]  slot_q;
	logic [kpt_pkg::ID_W-1:0]    id_out_q;
	logic [kpt_pkg::KEY_W-1:0]   key_out_q;
	logic [kpt_pkg::LIVE_W-1:0]  live_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        res_load;
	logic                        issue;
	logic                        hit;
	logic                        scan_hit;
	kpt_pkg::entry_t             rd_entry;
	kpt_pkg::entry_t             wr_entry;
	kpt_pkg::probe_t             probe;

	// result decode
	kpt_pkg::status_t            res_status;
	logic                        res_has;
	logic [IW-1:0]               res_idx;
	kpt_pkg::entry_t             res_entry;
	logic                        set_en;
	logic                        clr_en;
	logic [CW-1:0]               cnt_next;

	// Take a new transaction only while idle; a pending result in the output register does not block.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign res_load = (state_q == S_RESULT) && out_free;

	// Issue one slot read per scan cycle until every slot has been read.
	assign issue    = (state_q == S_SCAN) && (rd_cnt_q < CW'(TABLE_ENTRIES));

	assign wr_entry = '{id: id_q, key: key_q};

	kpt_ram #(
		.WIDTH (kpt_pkg::ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (res_load && set_en),
		.waddr (free_idx_q),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rd_entry)
	);

	// Compare the entry read last cycle; its valid mark comes from the flops.
	assign probe.by_id = (cmd_q == kpt_pkg::CMD_FIND_ID);
	assign probe.live  = valid_q[cmp_idx_s1];

	kpt_match u_match (
		.probe (probe),
		.key   (key_q),
		.id    (id_q),
		.entry (rd_entry),
		.hit   (hit)
	);

	assign scan_hit = (state_q == S_SCAN) && cmp_vld_s1 && hit;

	// Work out the result and the table update from what the scan found.
	always_comb begin
		res_status = kpt_pkg::ST_NOT_FOUND;
		res_has    = 1'b0;
		res_idx    = match_idx_q;
		res_entry  = match_entry_q;
		set_en     = 1'b0;
		clr_en     = 1'b0;
		cnt_next   = count_q;
		if (match_q) begin
			res_has = 1'b1;
			if (cmd_q == kpt_pkg::CMD_REMOVE) begin
				res_status = kpt_pkg::ST_DONE;
				clr_en     = 1'b1;
				if (count_q != '0) begin
					cnt_next = count_q - 1'b1;
				end
			end else begin
				res_status = kpt_pkg::ST_FOUND;
			end
		end else begin
			case (cmd_q)
				kpt_pkg::CMD_INSERT: begin
					if (free_q) begin
						// Fill the lowest free slot; the result shows the new entry.
						res_status = kpt_pkg::ST_DONE;
						res_has    = 1'b1;
						res_idx    = free_idx_q;
						res_entry  = wr_entry;
						set_en     = 1'b1;
						cnt_next   = count_q + 1'b1;
					end else begin
						res_status = kpt_pkg::ST_FULL;
					end
				end
				default: begin
					res_status = kpt_pkg::ST_NOT_FOUND;
				end
			endcase
		end
	end

	// Sequencer: hold state, scan pointers, valid marks, count and out_valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cmp_idx_s1  <= '0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
		end else begin
			// Drop the result once it has been taken, unless a new one replaces it.
			if (out_valid_q && !out_stall && !res_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q    <= S_SCAN;
						rd_cnt_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						match_q    <= 1'b0;
						free_q     <= 1'b0;
					end
				end
				S_SCAN: begin
					// Advance the read pointer; the compare works on the previous read.
					if (issue) begin
						cmp_vld_s1  <= 1'b1;
						cmp_idx_s1  <= rd_cnt_q[IW-1:0];
						cmp_last_s1 <= (rd_cnt_q == CW'(TABLE_ENTRIES - 1));
						rd_cnt_q    <= rd_cnt_q + 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1) begin
						// Remember the lowest free slot seen so far for insert.
						if (!valid_q[cmp_idx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
						if (hit) begin
							match_q     <= 1'b1;
							match_idx_q <= cmp_idx_s1;
							state_q     <= S_RESULT;
						end else if (cmp_last_s1) begin
							state_q <= S_RESULT;
						end
					end
				end
				S_RESULT: begin
					// Hold until the output register is free, then commit.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						count_q     <= cnt_next;
						if (set_en) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (clr_en) begin
							valid_q[match_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: command capture, matched entry, result fields.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= kpt_pkg::cmd_t'(cmd);
			key_q <= {key_word3, key_word2, key_word1, key_word0};
			id_q  <= peer_id;
		end
		if (scan_hit) begin
			match_entry_q <= rd_entry;
		end
		if (res_load) begin
			status_q  <= res_status;
			slot_q    <= res_has ? kpt_pkg::SLOT_W'(res_idx) : '0;
			id_out_q  <= res_has ? res_entry.id : '0;
			key_out_q <= res_has ? res_entry.key : '0;
			live_q    <= kpt_pkg::LIVE_W'(cnt_next);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign stored_id       = id_out_q;
	assign found_key_word0 = key_out_q[kpt_pkg::WORD_W-1:0];
	assign found_key_word1 = key_out_q[2*kpt_pkg::WORD_W-1:kpt_pkg::WORD_W];
	assign found_key_word2 = key_out_q[3*kpt_pkg::WORD_W-1:2*kpt_pkg::WORD_W];
	assign found_key_word3 = key_out_q[4*kpt_pkg::WORD_W-1:3*kpt_pkg::WORD_W];
	assign live_count      = live_q;

	// The live count always equals the number of valid marks.
	a_count_matches_marks: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("live count out of step with valid marks");

	// An insert only writes a slot that is free.
	a_write_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && set_en) |-> !valid_q[free_idx_q])
		else $error("insert overwrote a live entry");

	// Table full is only reported when every slot is live.
	a_full_all_live: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res_status == kpt_pkg::ST_FULL)) |-> (&valid_q))
		else $error("table full reported with a free slot");

	// A result appears only out of the commit state.
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESULT))
		else $error("result raised outside commit");

endmodule

@@ verif/keyed_peer_table_chk.sv @@
// keyed_peer_table_chk: watches both channels of keyed_peer_table, predicts every reply
// from its own copy of the table and compares it field by field. Depends on kpt_pkg.

module keyed_peer_table_chk #(
	parameter int ENTRIES = kpt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   cmd,
	input  logic [kpt_pkg::WORD_W-1:0]   key_word0,
	input  logic [kpt_pkg::WORD_W-1:0]   key_word1,
	input  logic [kpt_pkg::WORD_W-1:0]   key_word2,
	input  logic [kpt_pkg::WORD_W-1:0]   key_word3,
	input  logic [kpt_pkg::ID_W-1:0]     peer_id,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [1:0]                   status,
	input  logic [kpt_pkg::SLOT_W-1:0]   slot,
	input  logic [kpt_pkg::ID_W-1:0]     stored_id,
	input  logic [kpt_pkg::WORD_W-1:0]   found_key_word0,
	input  logic [kpt_pkg::WORD_W-1:0]   found_key_word1,
	input  logic [kpt_pkg::WORD_W-1:0]   found_key_word2,
	input  logic [kpt_pkg::WORD_W-1:0]   found_key_word3,
	input  logic [kpt_pkg::LIVE_W-1:0]   live_count,
	output int                           fails,
	output int                           pending,
	output int                           checked,
	output int                           full_seen,
	output int                           peak_live
);
	import kpt_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [KEY_W-1:0]  key;
		logic [LIVE_W-1:0] live;
	} peer_reply_t;

	// Shadow table
	logic             tbl_live [ENTRIES];
	logic [KEY_W-1:0] tbl_key  [ENTRIES];
	logic [ID_W-1:0]  tbl_id   [ENTRIES];
	int               tbl_count;

	peer_reply_t reply_q [$];
	peer_reply_t want;
	peer_reply_t got;
	int          fail_cnt;
	int          check_cnt;
	int          full_cnt;
	int          live_max;

	function automatic peer_reply_t apply_command(cmd_t op, logic [KEY_W-1:0] key,
			logic [ID_W-1:0] pid);
		int          hit;
		int          free_slot;
		peer_reply_t r;
		hit = -1;
		free_slot = -1;
		for (int s = 0; s < ENTRIES; s++) begin
			if (hit < 0 && tbl_live[s] &&
					((op == CMD_FIND_ID) ? (tbl_id[s] == pid) : (tbl_key[s] == key)))
				hit = s;
			if (free_slot < 0 && !tbl_live[s])
				free_slot = s;
		end
		r = '0;
		r.status = ST_NOT_FOUND;
		case (op)
			CMD_INSERT: begin
				if (hit >= 0)
					r.status = ST_FOUND;
				else if (free_slot < 0)
					r.status = ST_FULL;
				else begin
					tbl_key[free_slot] = key;
					tbl_id[free_slot] = pid;
					tbl_live[free_slot] = 1'b1;
					tbl_count++;
					hit = free_slot;
					r.status = ST_DONE;
				end
			end
			CMD_FIND_KEY, CMD_FIND_ID: begin
				if (hit >= 0)
					r.status = ST_FOUND;
			end
			default: begin
				// removed entry keeps its key and id in the store
				if (hit >= 0) begin
					tbl_live[hit] = 1'b0;
					if (tbl_count > 0)
						tbl_count--;
					r.status = ST_DONE;
				end
			end
		endcase
		if (hit >= 0) begin
			r.slot = hit[SLOT_W-1:0];
			r.id = tbl_id[hit];
			r.key = tbl_key[hit];
		end
		r.live = tbl_count[LIVE_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [KEY_W-1:0] w, logic [KEY_W-1:0] g);
		if (w !== g) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, w, g);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (tbl_live[s])
				tbl_live[s] = 1'b0;
			tbl_count = 0;
			reply_q.delete();
			fail_cnt = 0;
			check_cnt = 0;
			full_cnt = 0;
			live_max = 0;
		end else begin
			// retire the reply first, then predict the new command
			if (out_valid && !out_stall) begin
				got.status = status_t'(status);
				got.slot = slot;
				got.id = stored_id;
				got.key = {found_key_word3, found_key_word2, found_key_word1, found_key_word0};
				got.live = live_count;
				if (reply_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected reply, expected none, actual status %0d slot %0d",
						$time, status, slot);
				end else begin
					want = reply_q.pop_front();
					check_field("status", KEY_W'(want.status), KEY_W'(got.status));
					check_field("slot", KEY_W'(want.slot), KEY_W'(got.slot));
					check_field("stored_id", KEY_W'(want.id), KEY_W'(got.id));
					check_field("found_key", want.key, got.key);
					check_field("live_count", KEY_W'(want.live), KEY_W'(got.live));
					check_cnt++;
					if (want.status == ST_FULL)
						full_cnt++;
				end
			end
			if (in_valid && !in_stall) begin
				reply_q.push_back(apply_command(cmd_t'(cmd),
					{key_word3, key_word2, key_word1, key_word0}, peer_id));
				if (tbl_count > live_max)
					live_max = tbl_count;
			end
		end
		fails <= fail_cnt;
		pending <= reply_q.size();
		checked <= check_cnt;
		full_seen <= full_cnt;
		peak_live <= live_max;
	end

endmodule

@@ verif/keyed_peer_table_tb.sv @@
// keyed_peer_table_tb: top of the keyed_peer_table testbench. Makes the command
// stimulus and the reply back-pressure; depends on kpt_pkg and keyed_peer_table_chk.

module keyed_peer_table_tb;
	import kpt_pkg::*;

	localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
	localparam int KEY_POOL = 32;
	localparam int ID_POOL = 8;
	localparam int HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = CMD_INSERT;
	logic [WORD_W-1:0] key_word0 = '0;
	logic [WORD_W-1:0] key_word1 = '0;
	logic [WORD_W-1:0] key_word2 = '0;
	logic [WORD_W-1:0] key_word3 = '0;
	logic [ID_W-1:0]   peer_id = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [ID_W-1:0]   stored_id;
	logic [WORD_W-1:0] found_key_word0;
	logic [WORD_W-1:0] found_key_word1;
	logic [WORD_W-1:0] found_key_word2;
	logic [WORD_W-1:0] found_key_word3;
	logic [LIVE_W-1:0] live_count;

	int fails;
	int pending;
	int checked;
	int full_seen;
	int peak_live;

	// Idling rates in percent, changed only between phases
	int in_idle_pct = 24;
	int out_idle_pct = 47;
	// Long hold-off requests, served by the receiver process
	int hold_reqs = 0;
	int holds_served = 0;
	int hold_left = 0;

	int cmd_sent [4];
	logic [KEY_W-1:0] key_pool [KEY_POOL];
	logic [ID_W-1:0]  id_pool [ID_POOL];

	always #10 clk = ~clk;

	keyed_peer_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.key_word0(key_word0),
		.key_word1(key_word1),
		.key_word2(key_word2),
		.key_word3(key_word3),
		.peer_id(peer_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot(slot),
		.stored_id(stored_id),
		.found_key_word0(found_key_word0),
		.found_key_word1(found_key_word1),
		.found_key_word2(found_key_word2),
		.found_key_word3(found_key_word3),
		.live_count(live_count)
	);

	keyed_peer_table_chk #(
		.ENTRIES(TABLE_ENTRIES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.key_word0(key_word0),
		.key_word1(key_word1),
		.key_word2(key_word2),
		.key_word3(key_word3),
		.peer_id(peer_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot(slot),
		.stored_id(stored_id),
		.found_key_word0(found_key_word0),
		.found_key_word1(found_key_word1),
		.found_key_word2(found_key_word2),
		.found_key_word3(found_key_word3),
		.live_count(live_count),
		.fails(fails),
		.pending(pending),
		.checked(checked),
		.full_seen(full_seen),
		.peak_live(peak_live)
	);

	// Reply side: a pending long hold-off wins, otherwise stall at the current rate.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_reqs) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Mostly keys from the pool so that hits, duplicates and a full table occur;
	// the rest are fresh keys that toggle every bit.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(KEY_POOL - 1)];
		return random_key();
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 65)
			return id_pool[$urandom_range(ID_POOL - 1)];
		return ID_W'($urandom_range(16'hFFFF));
	endfunction

	// Offer one command after a random gap and hold it until the transaction
	// completes. Leave valid high afterwards so back-to-back commands need no toggle.
	task automatic offer(cmd_t op, logic [KEY_W-1:0] key, logic [ID_W-1:0] pid);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key_word0 <= key[63:0];
		key_word1 <= key[127:64];
		key_word2 <= key[191:128];
		key_word3 <= key[255:192];
		peer_id <= pid;
		do
			@(posedge clk);
		while (in_stall);
		cmd_sent[op]++;
	endtask

	// Drop valid and wait until every reply has been taken.
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Switch idling rates with valid low; optionally start a long reply hold-off.
	task automatic enter_phase(int in_pct, int out_pct, bit with_hold);
		in_idle_pct <= in_pct;
		out_idle_pct <= out_pct;
		if (with_hold)
			hold_reqs <= hold_reqs + 1;
		@(posedge clk);
	endtask

	// Random command with the given insert / find-by-key / find-by-id weights;
	// the remainder goes to remove.
	task automatic random_commands(int count, int ins_pct, int fk_pct, int fi_pct);
		int   r;
		cmd_t op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				op = CMD_INSERT;
			else if (r < ins_pct + fk_pct)
				op = CMD_FIND_KEY;
			else if (r < ins_pct + fk_pct + fi_pct)
				op = CMD_FIND_ID;
			else
				op = CMD_REMOVE;
			offer(op, pick_key(), pick_id());
		end
	endtask

	initial begin
		// Key pool: the extremes, two checkerboards, then groups of near misses
		// (one random key followed by copies with a single bit flipped).
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = {(KEY_W / 2){2'b01}};
		key_pool[3] = {(KEY_W / 2){2'b10}};
		for (int k = 4; k < KEY_POOL; k++) begin
			if (k % 4 == 0)
				key_pool[k] = random_key();
			else
				key_pool[k] = key_pool[k - 1] ^ (256'd1 << $urandom_range(KEY_W - 1));
		end
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		id_pool[2] = 16'h8001;
		id_pool[3] = 16'h1234;
		for (int k = 4; k < ID_POOL; k++)
			id_pool[k] = ID_W'($urandom_range(16'hFFFF));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme keys and ids, duplicate insert that must
		// keep the old id, lowest match for a shared id, remove and refill of the
		// lowest hole, then fill the table and insert once more into a full table.
		offer(CMD_FIND_KEY, '0, 16'h0000);
		offer(CMD_INSERT, '0, 16'h0000);
		offer(CMD_INSERT, '1, 16'hFFFF);
		offer(CMD_INSERT, '0, 16'h1234);
		offer(CMD_INSERT, '1 ^ 256'd1, 16'hFFFF);
		offer(CMD_FIND_ID, random_key(), 16'hFFFF);
		offer(CMD_REMOVE, '0, 16'h0000);
		offer(CMD_FIND_ID, '0, 16'h0000);
		offer(CMD_REMOVE, '0, 16'h0000);
		offer(CMD_INSERT, key_pool[2], 16'h8001);
		for (int n = 0; n < TABLE_ENTRIES - 3; n++)
			offer(CMD_INSERT, random_key(), ID_W'($urandom_range(16'hFFFF)));
		offer(CMD_INSERT, random_key(), 16'hFFFF);
		offer(CMD_FIND_KEY, '1, 16'h0000);
		drain_replies();

		// Phase one: insert-heavy so the table fills, with a long reply hold-off
		// at the start that backs the block up into its command input.
		enter_phase(24, 47, 1'b1);
		random_commands(280, 55, 15, 15);
		drain_replies();

		// Phase two: remove-heavy so the table drains, idling rates swapped.
		enter_phase(47, 24, 1'b0);
		random_commands(270, 20, 15, 15);
		drain_replies();

		// Phase three: balanced mix at full rate, another hold-off first.
		enter_phase(0, 0, 1'b1);
		random_commands(275, 35, 20, 20);
		drain_replies();
		repeat (TABLE_ENTRIES + 8) @(posedge clk);

		$display("commands: %0d insert, %0d find by key, %0d find by id, %0d remove",
			cmd_sent[CMD_INSERT], cmd_sent[CMD_FIND_KEY], cmd_sent[CMD_FIND_ID],
			cmd_sent[CMD_REMOVE]);
		$display("replies checked: %0d, table-full replies: %0d, peak live entries: %0d",
			checked, full_seen, peak_live);
		if (fails == 0)
			$display("keyed_peer_table_tb: PASS");
		else
			$display("keyed_peer_table_tb: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10000000;
		$display("keyed_peer_table_tb: FAIL");
		$finish;
	end

endmodule
